// ===== sv/vfme_pkg.sv =====
// Shared widths, constants and corner tables of the voxel face mesh emitter.
`timescale 1ns / 1ps

package vfme_pkg;

  localparam int POS_W   = 4;
  localparam int MASK_W  = 6;
  localparam int MAT_W   = 16;
  localparam int VS_W    = 16;
  localparam int COORD_W = 20;
  localparam int SEC_W   = 5;
  localparam int CNT_W   = 17;
  localparam int FACE_W  = 3;
  localparam int CRN_W   = 2;

  localparam int MAX_SECTIONS_DEF = 16;

  localparam logic [VS_W-1:0] VS_RESET = VS_W'(100);

  // Face codes, equal to their bit number in the face mask
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  localparam logic [CRN_W-1:0] CORNER_LAST = 2'd3;

  // Unit cube corners as {x, y, z} offsets in voxels
  localparam logic [2:0] CUBE_OFF [8] = '{
    3'b011, 3'b111, 3'b101, 3'b001,
    3'b010, 3'b110, 3'b100, 3'b000
  };

  // Cube corner of each face corner, indexed by {face, corner}
  localparam logic [2:0] FACE_CUBE [32] = '{
    3'd6, 3'd2, 3'd1, 3'd5,
    3'd4, 3'd0, 3'd3, 3'd7,
    3'd7, 3'd3, 3'd2, 3'd6,
    3'd5, 3'd1, 3'd0, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3,
    3'd7, 3'd6, 3'd5, 3'd4,
    3'd7, 3'd7, 3'd7, 3'd7,
    3'd7, 3'd7, 3'd7, 3'd7
  };

  function automatic logic [2:0] corner_off(input logic [FACE_W-1:0] face,
                                            input logic [CRN_W-1:0] crn);
    return CUBE_OFF[FACE_CUBE[{face, crn}]];
  endfunction

endpackage

// ===== sv/vfme_scale.sv =====
// Shared multiplier that scales the three voxel indices by the voxel size, one axis a cycle.
`timescale 1ns / 1ps

module vfme_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vfme_pkg::POS_W-1:0] pos_x,
  input  logic [vfme_pkg::POS_W-1:0] pos_y,
  input  logic [vfme_pkg::POS_W-1:0] pos_z,
  input  logic [vfme_pkg::VS_W-1:0]  voxel_size,
  output logic                       done,
  output logic [vfme_pkg::COORD_W-1:0] scaled_x,
  output logic [vfme_pkg::COORD_W-1:0] scaled_y,
  output logic [vfme_pkg::COORD_W-1:0] scaled_z
);
  import vfme_pkg::*;

  logic             busy;
  logic [1:0]       axis;
  logic [POS_W-1:0] op_x;
  logic [POS_W-1:0] op_y;
  logic [POS_W-1:0] op_z;
  logic [POS_W-1:0] op_sel;
  logic [COORD_W-1:0] prod;

  always_comb begin
    case (axis)
      2'd0:    op_sel = op_x;
      2'd1:    op_sel = op_y;
      default: op_sel = op_z;
    endcase
  end

  // Exact: a 4-bit index times a 16-bit size fits in 20 bits
  assign prod = COORD_W'(op_sel) * COORD_W'(voxel_size);
  assign done = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      axis <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      axis <= 2'd0;
    end else if (busy) begin
      axis <= axis + 2'd1;
      if (axis == 2'd2) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_x <= pos_x;
      op_y <= pos_y;
      op_z <= pos_z;
    end
    if (busy) begin
      case (axis)
        2'd0:    scaled_x <= prod;
        2'd1:    scaled_y <= prod;
        default: scaled_z <= prod;
      endcase
    end
  end

endmodule

// ===== sv/voxel_face_mesh_emitter.sv =====
// Top level of the voxel face mesh emitter: section lookup, vertex sequencer and output register.
`timescale 1ns / 1ps

// One voxel enters per input transaction; up to 24 vertex transactions leave, four per
// visible face in the order +x, -x, -y, +y, +z, -z, the final one marked with last. The
// material is searched in the section table one entry at a time (registered read of the
// material store, then compare) until it hits or the sections in use run out. The
// section's vertex count is then fetched, and the fetch also waits for the shared
// multiplier to scale the three indices. After that comes one cycle per vertex
// while the output side keeps up. The input is stalled for that whole span
// and is freed as soon as the last vertex sits in the output register. A voxel with no
// visible faces still claims a section and gives no output. A first_voxel item clears
// the table and every vertex count at once before its own lookup. When all
// MAX_SECTIONS sections are taken, faces of new materials come out with overflow set,
// section equal to MAX_SECTIONS and base_index zero, and no count moves. voxel_size may
// be written at any time the block is idle; cfg_ready is always high.
module voxel_face_mesh_emitter #(
  parameter int MAX_SECTIONS = vfme_pkg::MAX_SECTIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vfme_pkg::VS_W-1:0]     voxel_size,
  // voxel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [vfme_pkg::POS_W-1:0]    pos_x,
  input  logic [vfme_pkg::POS_W-1:0]    pos_y,
  input  logic [vfme_pkg::POS_W-1:0]    pos_z,
  input  logic [vfme_pkg::MASK_W-1:0]   face_mask,
  input  logic [vfme_pkg::MAT_W-1:0]    material_id,
  input  logic                          first_voxel,
  // vertex output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [vfme_pkg::SEC_W-1:0]    section,
  output logic [vfme_pkg::COORD_W-1:0]  vert_x,
  output logic [vfme_pkg::COORD_W-1:0]  vert_y,
  output logic [vfme_pkg::COORD_W-1:0]  vert_z,
  output logic [vfme_pkg::FACE_W-1:0]   normal_code,
  output logic                          tex_u,
  output logic                          tex_v,
  output logic [vfme_pkg::CRN_W-1:0]    corner,
  output logic [vfme_pkg::CNT_W-1:0]    base_index,
  output logic                          overflow,
  output logic                          last
);
  import vfme_pkg::*;

  localparam int IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SCNT_W = $clog2(MAX_SECTIONS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_BASE   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  // Lowest visible face still to emit
  function automatic logic [FACE_W-1:0] low_face(input logic [MASK_W-1:0] m);
    logic [FACE_W-1:0] f;
    f = FACE_NEG_Z;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        f = FACE_W'(i);
      end
    end
    return f;
  endfunction

  logic [2:0]         state;
  logic [VS_W-1:0]    vs;
  logic [SCNT_W-1:0]  sec_count;
  logic [SCNT_W-1:0]  idx;
  logic [IDX_W-1:0]   sec;
  logic               ovf;
  logic [MASK_W-1:0]  rem;
  logic [CRN_W-1:0]   crn;
  logic [MAT_W-1:0]   mat_q;
  logic [MAT_W-1:0]   mat_rd;
  logic [CNT_W-1:0]   base;
  logic [MAX_SECTIONS-1:0] vcnt_vld;

  logic [MAT_W-1:0]   mat_mem  [MAX_SECTIONS];
  logic [CNT_W-1:0]   vcnt_mem [MAX_SECTIONS];

  logic               in_go;
  logic               emit_go;
  logic               table_full;
  logic               scale_done;
  logic [COORD_W-1:0] scaled_x;
  logic [COORD_W-1:0] scaled_y;
  logic [COORD_W-1:0] scaled_z;
  logic [FACE_W-1:0]  face;
  logic [2:0]         off;
  logic [MASK_W-1:0]  rem_clr;
  logic               face_end;
  logic               vert_last;
  logic [COORD_W-1:0] vs_ext;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != ST_IDLE);
  assign in_go      = in_valid && !in_stall;
  assign emit_go    = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign table_full = (sec_count == SCNT_W'(MAX_SECTIONS));

  assign face      = low_face(rem);
  assign off       = corner_off(face, crn);
  assign rem_clr   = rem & ~(MASK_W'(1) << face);
  assign face_end  = (crn == CORNER_LAST);
  assign vert_last = face_end && (rem_clr == '0);
  assign vs_ext    = COORD_W'(vs);

  vfme_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (in_go),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .voxel_size (vs),
    .done       (scale_done),
    .scaled_x   (scaled_x),
    .scaled_y   (scaled_y),
    .scaled_z   (scaled_z)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vs        <= VS_RESET;
      sec_count <= '0;
      idx       <= '0;
      vcnt_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vs <= voxel_size;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_go) begin
            // new chunk: drop every section before the lookup
            if (first_voxel) begin
              sec_count <= '0;
              vcnt_vld  <= '0;
            end
            idx   <= '0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (idx == sec_count) begin
            // miss: claim the next section unless the table is full
            if (!table_full) begin
              sec_count <= sec_count + SCNT_W'(1);
            end
            state <= ST_BASE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (mat_rd == mat_q) begin
            state <= ST_BASE;
          end else begin
            idx   <= idx + SCNT_W'(1);
            state <= ST_SEARCH;
          end
        end
        ST_BASE: begin
          // hold until the scaled indices are ready
          if (scale_done) begin
            state <= (rem == '0) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (face_end && !ovf) begin
              vcnt_vld[sec] <= 1'b1;
            end
            if (vert_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Section stores, item registers and output payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_go) begin
          mat_q <= material_id;
          rem   <= face_mask;
          ovf   <= 1'b0;
        end
      end
      ST_SEARCH: begin
        if (idx == sec_count) begin
          if (table_full) begin
            ovf <= 1'b1;
          end else begin
            sec <= sec_count[IDX_W-1:0];
            mat_mem[sec_count[IDX_W-1:0]] <= mat_q;
          end
        end else begin
          mat_rd <= mat_mem[idx[IDX_W-1:0]];
        end
      end
      ST_CMP: begin
        if (mat_rd == mat_q) begin
          sec <= idx[IDX_W-1:0];
        end
      end
      ST_BASE: begin
        // an invalid count reads as zero; overflowed faces always start at zero
        if (ovf || !vcnt_vld[sec]) begin
          base <= '0;
        end else begin
          base <= vcnt_mem[sec];
        end
        crn <= '0;
      end
      ST_EMIT: begin
        if (emit_go) begin
          section     <= ovf ? SEC_W'(MAX_SECTIONS) : SEC_W'(sec);
          vert_x      <= off[2] ? scaled_x + vs_ext : scaled_x;
          vert_y      <= off[1] ? scaled_y + vs_ext : scaled_y;
          vert_z      <= off[0] ? scaled_z + vs_ext : scaled_z;
          normal_code <= face;
          tex_u       <= crn[1];
          tex_v       <= crn[1] ^ crn[0];
          corner      <= crn;
          base_index  <= base;
          overflow    <= ovf;
          last        <= vert_last;
          crn         <= crn + CRN_W'(1);
          if (face_end) begin
            rem <= rem_clr;
            if (!ovf) begin
              base          <= base + CNT_W'(4);
              vcnt_mem[sec] <= base + CNT_W'(4);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/vfme_checker.sv =====
// Port-level checker for the voxel face mesh emitter and its bind.
`timescale 1ns / 1ps

module vfme_checker #(
  parameter int MAX_SECTIONS = vfme_pkg::MAX_SECTIONS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [vfme_pkg::SEC_W-1:0]   section,
  input logic                         tex_u,
  input logic                         tex_v,
  input logic [vfme_pkg::CRN_W-1:0]   corner,
  input logic [vfme_pkg::CNT_W-1:0]   base_index,
  input logic                         overflow,
  input logic                         last
);
  import vfme_pkg::*;

  // a stalled vertex stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("vertex withdrawn while stalled");

  // an overflowed face carries the overflow section and a zero base
  a_ovf_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> section == SEC_W'(MAX_SECTIONS) && base_index == '0)
    else $error("overflow vertex with wrong section or base");

  // UV follows the corner number
  a_uv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u == corner[1] && tex_v == (corner[1] ^ corner[0]))
    else $error("UV does not match corner");

  // a voxel always ends on the closing corner of a quad
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> corner == CORNER_LAST)
    else $error("last flag on an inner corner");

  // no new voxel while this one still has vertices to come
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input open before the last vertex");

endmodule

bind voxel_face_mesh_emitter vfme_checker #(
  .MAX_SECTIONS (MAX_SECTIONS)
) u_vfme_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .section    (section),
  .tex_u      (tex_u),
  .tex_v      (tex_v),
  .corner     (corner),
  .base_index (base_index),
  .overflow   (overflow),
  .last       (last)
);
